FILE: design/vlbp_pkg.sv
// ----------------------------------------------------------------------------
// vlbp_pkg: shared definitions for the variable-length bit packer
// Word geometry, request kinds and the record that the merge logic hands
// back to the top level for one request.
// ----------------------------------------------------------------------------
package vlbp_pkg;

   localparam int WORD_BITS  = 32;
   localparam int COUNT_BITS = 6;   // holds 0..32 and a fill plus a length
   localparam int FILL_BITS  = 5;   // partial fill is 0..31

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [FILL_BITS-1:0]  fill_type;

   typedef enum logic {
      REQ_APPEND = 1'b0,
      REQ_FLUSH  = 1'b1
   } req_kind_type;

   localparam count_type FULL_COUNT = count_type'(WORD_BITS);

   // Outcome of one request against the current fill state.
   typedef struct packed {
      logic      emit;          // a word leaves with this request
      word_type  word;          // the word that leaves
      count_type bits;          // meaningful bits in that word
      logic      flush;         // word came from a flush request
      logic      update;        // the fill state changes
      word_type  next_partial;  // fill state after the request
      fill_type  next_fill;
   } step_type;

endpackage

FILE: design/vlbp_merge.sv
// ----------------------------------------------------------------------------
// vlbp_merge: shift-and-merge logic for one request
// Masks and places a field behind the bits already packed, and decides
// whether a word completes or a flush drains the partial word.
// ----------------------------------------------------------------------------
module vlbp_merge (
   input  vlbp_pkg::req_kind_type kind,
   input  vlbp_pkg::word_type     field_bits,
   input  vlbp_pkg::count_type    field_len,
   input  vlbp_pkg::word_type     partial,
   input  vlbp_pkg::fill_type     fill,
   output vlbp_pkg::step_type     step
);

   vlbp_pkg::count_type             len_sat;
   vlbp_pkg::word_type              masked;
   vlbp_pkg::count_type             total;
   vlbp_pkg::count_type             place;
   logic [2*vlbp_pkg::WORD_BITS-1:0] merged;

   // Lengths of 33 and above act as a full word.
   assign len_sat = field_len[vlbp_pkg::COUNT_BITS-1] ? vlbp_pkg::FULL_COUNT : field_len;
   assign masked  = field_bits & ({vlbp_pkg::WORD_BITS{1'b1}} >> (vlbp_pkg::FULL_COUNT - len_sat));
   assign total   = vlbp_pkg::count_type'(fill) + len_sat;

   // The field lands so that its lowest bit sits at bit (64 - total) of a
   // double word whose upper half is the partial word. Total is nonzero
   // whenever the result is used, so the modulo-64 shift count is exact.
   assign place  = vlbp_pkg::count_type'(0) - total;
   assign merged = {partial, vlbp_pkg::word_type'(0)}
                 | ({vlbp_pkg::word_type'(0), masked} << place);

   always_comb begin
      step              = '0;
      step.next_partial = partial;
      step.next_fill    = fill;
      if (kind == vlbp_pkg::REQ_FLUSH) begin
         if (fill != '0) begin
            step.emit   = 1'b1;
            step.word   = partial;
            step.bits   = vlbp_pkg::count_type'(fill);
            step.flush  = 1'b1;
            step.update = 1'b1;
            step.next_partial = '0;
            step.next_fill    = '0;
         end
      end else if (len_sat != '0) begin
         step.update       = 1'b1;
         step.next_fill    = total[vlbp_pkg::FILL_BITS-1:0];
         if (total[vlbp_pkg::COUNT_BITS-1]) begin
            // Word completed; any spill starts the next word.
            step.emit         = 1'b1;
            step.word         = merged[2*vlbp_pkg::WORD_BITS-1:vlbp_pkg::WORD_BITS];
            step.bits         = vlbp_pkg::FULL_COUNT;
            step.next_partial = merged[vlbp_pkg::WORD_BITS-1:0];
         end else begin
            step.next_partial = merged[2*vlbp_pkg::WORD_BITS-1:vlbp_pkg::WORD_BITS];
         end
      end
   end

endmodule

FILE: design/variable_length_bit_packer.sv
// ----------------------------------------------------------------------------
// variable_length_bit_packer: MSB-first packer of variable-length fields
// Path: an accepted item passes the input register, then the result register,
//    before the word that it completes leaves the output register.
// Throughput: one item per cycle; the only stall is a full result register
//    that the consumer does not take while the next item would emit a word.
// Reset: synchronous, active high; empties both registers and clears the
//    partial word and its fill count.
// ----------------------------------------------------------------------------
module variable_length_bit_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] field_bits, [37:32] field_len, rest zero
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] packed_word, [37:32] valid_bits, rest zero
   output logic        rsp_tuser    // [0] is_flush
);

   // Input register: holds one accepted item until the merge logic has
   // applied it to the fill state.
   logic                   req_vld_ff;
   vlbp_pkg::req_kind_type req_kind_ff;
   vlbp_pkg::word_type     req_bits_ff;
   vlbp_pkg::count_type    req_len_ff;

   // Fill state: the bits packed so far and how many of them there are.
   vlbp_pkg::word_type     partial_ff, partial_in;
   vlbp_pkg::fill_type     fill_ff, fill_in;

   // Result register: decouples the consumer from the merge logic.
   logic                   rsp_vld_ff;
   vlbp_pkg::word_type     rsp_word_ff;
   vlbp_pkg::count_type    rsp_bits_ff;
   logic                   rsp_flush_ff;

   vlbp_pkg::step_type     step;
   logic                   stall;
   logic                   advance;
   logic                   req_take;

   vlbp_merge u_merge (
      .kind       (req_kind_ff),
      .field_bits (req_bits_ff),
      .field_len  (req_len_ff),
      .partial    (partial_ff),
      .fill       (fill_ff),
      .step       (step)
   );

   // The held item only waits when it would emit a word and the result
   // register still holds one the consumer has not taken. Items that emit
   // nothing always pass straight through.
   assign stall    = req_vld_ff && step.emit && rsp_vld_ff && !rsp_tready;
   assign advance  = req_vld_ff && !stall;
   assign req_tready = !stall;
   assign req_take = req_tvalid && req_tready;

   assign partial_in = (advance && step.update) ? step.next_partial : partial_ff;
   assign fill_in    = (advance && step.update) ? step.next_fill    : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         partial_ff <= '0;
         fill_ff    <= '0;
      end else begin
         partial_ff <= partial_in;
         fill_ff    <= fill_in;

         if (req_take) begin
            req_vld_ff <= 1'b1;
         end else if (advance) begin
            req_vld_ff <= 1'b0;
         end

         if (advance && step.emit) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_kind_ff <= vlbp_pkg::req_kind_type'(req_tuser);
         req_bits_ff <= req_tdata[31:0];
         req_len_ff  <= req_tdata[37:32];
      end
      if (advance && step.emit) begin
         rsp_word_ff  <= step.word;
         rsp_bits_ff  <= step.bits;
         rsp_flush_ff <= step.flush;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {2'b00, rsp_bits_ff, rsp_word_ff};
   assign rsp_tuser  = rsp_flush_ff;

endmodule
